### rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mks_pkg.sv
package mks_pkg;

  localparam int unsigned COLS_W  = 4;
  localparam int unsigned ROWS_W  = 4;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned TICK_W  = 8;
  localparam int unsigned ROW_IDX_W = 2;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DATA_W = 8;

  // All column lines high: no key pressed.
  localparam logic [COLS_W-1:0] COLS_IDLE = 4'hF;
  localparam logic [COLS_W-1:0] COL1_LOW  = 4'hD;
  localparam logic [COLS_W-1:0] COL2_LOW  = 4'hB;

  localparam logic [TICK_W-1:0] POLL_TICKS_RESET    = 8'd20;
  localparam logic [TICK_W-1:0] CONFIRM_TICKS_RESET = 8'd40;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_TICKS    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_TICKS = 8'd1;

  typedef struct packed {
    logic [ROWS_W-1:0] row_drive;
    logic              key_valid;
    logic [CODE_W-1:0] key_code;
  } result_t;

  // Row drive pattern with the selected row pulled low.
  function automatic logic [ROWS_W-1:0] row_pattern(input logic [ROW_IDX_W-1:0] row);
    logic [ROWS_W-1:0] pat;
    unique case (row)
      2'd0:    pat = 4'hE;
      2'd1:    pat = 4'hD;
      2'd2:    pat = 4'hB;
      default: pat = 4'h7;
    endcase
    return pat;
  endfunction

  // Character of the key at a row and a column pattern. Any pattern other
  // than the second or third column low reads the last table column.
  function automatic logic [CODE_W-1:0] key_char(input logic [ROW_IDX_W-1:0] row,
                                                 input logic [COLS_W-1:0] cols);
    logic [CODE_W-1:0] ch;
    if (cols == COL1_LOW) begin
      unique case (row)
        2'd0:    ch = "8";
        2'd1:    ch = "5";
        2'd2:    ch = "2";
        default: ch = "0";
      endcase
    end else if (cols == COL2_LOW) begin
      unique case (row)
        2'd0:    ch = "9";
        2'd1:    ch = "6";
        2'd2:    ch = "3";
        default: ch = "#";
      endcase
    end else begin
      unique case (row)
        2'd0:    ch = "7";
        2'd1:    ch = "4";
        2'd2:    ch = "1";
        default: ch = "*";
      endcase
    end
    return ch;
  endfunction

endpackage

### rtl/mks_sample_if.sv
interface mks_sample_if;
  import mks_pkg::*;
  logic              valid;
  logic              ready;
  logic [COLS_W-1:0] column_sample;

  modport source (output valid, output column_sample, input ready);
  modport sink (input valid, input column_sample, output ready);
endinterface

### rtl/mks_result_if.sv
interface mks_result_if;
  import mks_pkg::*;
  logic              valid;
  logic              ready;
  logic [ROWS_W-1:0] row_drive;
  logic              key_valid;
  logic [CODE_W-1:0] key_code;

  modport source (output valid, output row_drive, output key_valid, output key_code,
                  input ready);
  modport sink (input valid, input row_drive, input key_valid, input key_code,
                output ready);
endinterface

### rtl/mks_cfg_if.sv
interface mks_cfg_if;
  import mks_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/mks_core.sv
module mks_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [mks_pkg::COLS_W-1:0]    cols,
  input  logic [mks_pkg::TICK_W-1:0]    poll_ticks,
  input  logic [mks_pkg::TICK_W-1:0]    confirm_ticks,
  output mks_pkg::result_t              res
);
  import mks_pkg::*;

  typedef enum logic [1:0] {
    PH_RELEASE,
    PH_POLL,
    PH_CONFIRM,
    PH_SCAN
  } phase_t;

  phase_t               phase, phase_next;
  logic [TICK_W-1:0]    tick_count, tick_count_next;
  logic [ROW_IDX_W-1:0] row_index, row_index_next;

  logic [TICK_W:0]      tick_inc;
  logic [TICK_W-1:0]    period;
  logic                 period_done;
  logic [TICK_W-1:0]    tick_adv;
  logic                 idle;

  always_comb begin
    tick_inc    = {1'b0, tick_count} + {{TICK_W{1'b0}}, 1'b1};
    period      = (phase == PH_CONFIRM) ? confirm_ticks : poll_ticks;
    period_done = (tick_inc >= {1'b0, period});
    tick_adv    = period_done ? '0 : tick_inc[TICK_W-1:0];
    idle        = (cols == COLS_IDLE);

    phase_next      = phase;
    tick_count_next = tick_count;
    row_index_next  = row_index;
    res.key_valid   = 1'b0;
    res.key_code    = '0;

    unique case (phase)
      PH_RELEASE: begin
        if (idle) begin
          phase_next      = PH_POLL;
          tick_count_next = '0;
        end
      end
      PH_POLL: begin
        tick_count_next = tick_adv;
        if (period_done && !idle) begin
          phase_next = PH_CONFIRM;
        end
      end
      PH_CONFIRM: begin
        tick_count_next = tick_adv;
        if (period_done) begin
          if (idle) begin
            phase_next = PH_POLL;
          end else begin
            phase_next     = PH_SCAN;
            row_index_next = '0;
          end
        end
      end
      PH_SCAN: begin
        if (!idle) begin
          res.key_valid   = 1'b1;
          res.key_code    = key_char(row_index, cols);
          phase_next      = PH_RELEASE;
          tick_count_next = '0;
          row_index_next  = '0;
        end else if (row_index == {ROW_IDX_W{1'b1}}) begin
          phase_next      = PH_RELEASE;
          tick_count_next = '0;
          row_index_next  = '0;
        end else begin
          row_index_next = row_index + 1'b1;
        end
      end
      default: begin
        phase_next = PH_RELEASE;
      end
    endcase

    res.row_drive = (phase_next == PH_SCAN) ? row_pattern(row_index_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_RELEASE;
      tick_count <= '0;
      row_index  <= '0;
    end else if (step) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      row_index  <= row_index_next;
    end
  end

endmodule

### rtl/matrix_keypad_scanner_unit.sv
// After its sample is accepted, a result passes the input register, then the
// scan step into the result register.
// Throughput: one sample per cycle while the result side does not stall.
// Reset (rst, synchronous, active high) empties both registers, puts the
// scanner in its wait-for-release phase and loads the tick registers with 20 and 40.
`include "assert_macros.svh"

module matrix_keypad_scanner_unit (
  input  logic            clk,
  input  logic            rst,
  mks_sample_if.sink      sample,
  mks_result_if.source    result,
  mks_cfg_if.sink         cfg
);
  import mks_pkg::*;

  // Configuration registers. Writes must arrive only while the scanner is idle;
  // the block does not enforce this and accepts all; an index beyond the list is dropped.
  logic [TICK_W-1:0] poll_ticks;
  logic [TICK_W-1:0] confirm_ticks;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_ticks    <= POLL_TICKS_RESET;
      confirm_ticks <= CONFIRM_TICKS_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_POLL_TICKS) begin
        poll_ticks <= cfg.data;
      end else if (cfg.index == CFG_CONFIRM_TICKS) begin
        confirm_ticks <= cfg.data;
      end
    end
  end

  // Input register. It holds one sampled column transaction until the scan
  // step can pass its result into the output register.
  logic              in_valid;
  logic [COLS_W-1:0] in_cols;

  // The scan step runs when a sample is waiting and the result register is
  // either empty or being drained this cycle. Only then does the state move.
  logic    step;
  result_t step_res;

  assign step         = in_valid && (!result.valid || result.ready);
  assign sample.ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_cols <= sample.column_sample;
    end
  end

  mks_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .cols          (in_cols),
    .poll_ticks    (poll_ticks),
    .confirm_ticks (confirm_ticks),
    .res           (step_res)
  );

  // Result register. A waiting result holds the scan step, so the input
  // register can still take one more sample before the input side stalls.
  logic    out_valid;
  result_t out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= step_res;
    end
  end

  assign result.valid     = out_valid;
  assign result.row_drive = out_res.row_drive;
  assign result.key_valid = out_res.key_valid;
  assign result.key_code  = out_res.key_code;

  // A decoded key always sends the scanner back to release with all rows low.
  `ASSERT_NOW(a_key_rows_low, out_valid && out_res.key_valid, out_res.row_drive == '0, "rows driven")
  // A decoded key carries a real character, and no key means a zero code.
  `ASSERT_NOW(a_key_code, out_valid, out_res.key_valid == (out_res.key_code != '0), "bad key code")
  // A sample held in the input register is not lost while the result side stalls.
  `ASSERT_NEXT(a_in_hold, in_valid && !step, in_valid && $stable(in_cols), "sample dropped")

endmodule

### tb/tb_matrix_keypad_scanner_unit.sv
`timescale 1ns / 1ps

module tb_matrix_keypad_scanner_unit;
  import mks_pkg::*;

  // Scanner phases, in the order the scanner walks through them.
  typedef enum logic [1:0] {
    PH_RELEASE,
    PH_POLL,
    PH_CONFIRM,
    PH_SCAN
  } scan_phase_t;

  // One line of the directed script. When has_want is set, the result is
  // the value typed in here; otherwise the scan predictor supplies it.
  typedef struct packed {
    logic [COLS_W-1:0] lines;
    logic              has_want;
    result_t           want;
  } script_row_t;

  // Register indexes that map to no register; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_LO = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_HI = 8'hFF;

  // Cycles without any transaction before the run is declared hung.
  localparam int QUIET_LIMIT = 4000;
  // Cycles the result side holds off during the pressure phase.
  localparam int HOLDOFF_CYCLES = 300;
  localparam int SCRIPT_LEN = 26;

  // The directed script runs with both periods set to one tick, so every
  // phase change happens on the very next sample. Rows with a typed result
  // are the easy ones: a fresh reset, a plain release, a scan with no key and decoded keys.
  localparam script_row_t KEY_SCRIPT [SCRIPT_LEN] = '{
    // A press right after reset is ignored until the keypad is released.
    '{4'h0, 1'b1, '{4'h0, 1'b0, 8'h00}},
    '{4'hF, 1'b1, '{4'h0, 1'b0, 8'h00}},
    // Column zero low: decodes through the last table column.
    '{4'hE, 1'b0, '0},
    '{4'hE, 1'b0, '0},
    '{4'hE, 1'b1, '{4'h0, 1'b1, "7"}},
    // Column three low, only found on the last row.
    '{4'hF, 1'b0, '0},
    '{4'h7, 1'b0, '0},
    '{4'h7, 1'b0, '0},
    '{4'hF, 1'b0, '0},
    '{4'hF, 1'b0, '0},
    '{4'hF, 1'b0, '0},
    '{4'h7, 1'b1, '{4'h0, 1'b1, "*"}},
    // The press is gone when it is confirmed: back to polling.
    '{4'hF, 1'b0, '0},
    '{4'hD, 1'b0, '0},
    '{4'hF, 1'b0, '0},
    // Confirmed press, but no row answers during the row scan.
    '{4'hB, 1'b0, '0},
    '{4'hB, 1'b0, '0},
    '{4'hF, 1'b0, '0},
    '{4'hF, 1'b0, '0},
    '{4'hF, 1'b0, '0},
    '{4'hF, 1'b1, '{4'h0, 1'b0, 8'h00}},
    // All columns low while polling, then column two on the second row.
    '{4'hF, 1'b0, '0},
    '{4'h0, 1'b0, '0},
    '{4'h0, 1'b0, '0},
    '{4'hF, 1'b0, '0},
    '{4'hB, 1'b1, '{4'h0, 1'b1, "6"}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  mks_sample_if smp ();
  mks_result_if res ();
  mks_cfg_if    cfg_ch ();

  matrix_keypad_scanner_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (smp),
    .result (res),
    .cfg    (cfg_ch)
  );

  // 4 ns period: two ns high, two ns low.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Scan predictor state and its copy of the two period registers.
  scan_phase_t            pr_phase;
  logic [TICK_W-1:0]      pr_ticks;
  logic [ROW_IDX_W-1:0]   pr_row;
  logic [CFG_DATA_W-1:0]  poll_period;
  logic [CFG_DATA_W-1:0]  confirm_period;
  // Row drive announced by the most recent sample; the keypad model answers
  // the next sample under it.
  logic [ROWS_W-1:0]      last_drive;

  // Results still owed by the block, oldest first.
  result_t expected_keys [$];

  int mismatches;
  int tx_idle_pct;
  int rx_stall_pct;
  int rx_holdoff_req;
  int rx_holdoff_left;
  int quiet_cycles;

  // Keypad model used by the random stimulus: one key at a time, held or
  // released for a random number of ticks.
  logic             key_down;
  logic [1:0]       key_row;
  logic [1:0]       key_col;
  int               hold_left;

  // Counts one tick toward a period. Returns 1 when the period has run out,
  // in which case the counter starts over. A period of zero behaves as one.
  function automatic logic tick_elapsed(input logic [CFG_DATA_W-1:0] period);
    logic [TICK_W:0] nxt;
    nxt = {1'b0, pr_ticks} + 1'b1;
    if (nxt >= {1'b0, period}) begin
      pr_ticks = '0;
      return 1'b1;
    end
    pr_ticks = nxt[TICK_W-1:0];
    return 1'b0;
  endfunction

  // Advances the predictor by one tick and returns the result it owes.
  function automatic result_t scan_tick(input logic [COLS_W-1:0] lines);
    result_t r;
    logic    hit;
    int      col;
    r = '0;
    case (pr_phase)
      PH_RELEASE: begin
        if (lines == COLS_IDLE) begin
          pr_phase = PH_POLL;
          pr_ticks = '0;
        end
      end
      PH_POLL: begin
        hit = tick_elapsed(poll_period);
        if (hit && lines != COLS_IDLE) pr_phase = PH_CONFIRM;
      end
      PH_CONFIRM: begin
        hit = tick_elapsed(confirm_period);
        if (hit) begin
          if (lines == COLS_IDLE) begin
            pr_phase = PH_POLL;
          end else begin
            pr_phase = PH_SCAN;
            pr_row = '0;
          end
        end
      end
      default: begin
        if (lines != COLS_IDLE) begin
          // Only the second and third columns are told apart; anything else
          // reads the first column, which matches the last one.
          col = (lines == COL1_LOW) ? 1 : (lines == COL2_LOW) ? 2 : 0;
          r.key_valid = 1'b1;
          case ({pr_row, col[1:0]})
            4'b00_00: r.key_code = "7";
            4'b00_01: r.key_code = "8";
            4'b00_10: r.key_code = "9";
            4'b01_00: r.key_code = "4";
            4'b01_01: r.key_code = "5";
            4'b01_10: r.key_code = "6";
            4'b10_00: r.key_code = "1";
            4'b10_01: r.key_code = "2";
            4'b10_10: r.key_code = "3";
            4'b11_00: r.key_code = "*";
            4'b11_01: r.key_code = "0";
            default:  r.key_code = "#";
          endcase
          pr_phase = PH_RELEASE;
          pr_ticks = '0;
          pr_row = '0;
        end else if (pr_row == 2'd3) begin
          pr_phase = PH_RELEASE;
          pr_ticks = '0;
          pr_row = '0;
        end else begin
          pr_row = pr_row + 1'b1;
        end
      end
    endcase
    if (pr_phase == PH_SCAN) begin
      case (pr_row)
        2'd0:    r.row_drive = 4'hE;
        2'd1:    r.row_drive = 4'hD;
        2'd2:    r.row_drive = 4'hB;
        default: r.row_drive = 4'h7;
      endcase
    end
    return r;
  endfunction

  // Column lines the keypad shows this tick. Hold times scale with the
  // current periods so that most presses survive polling and confirmation,
  // while some are released early. A slice of ticks carries random noise.
  function automatic logic [COLS_W-1:0] keypad_lines();
    logic [COLS_W-1:0] lines;
    int                span;
    span = int'(poll_period) + int'(confirm_period);
    if (hold_left == 0) begin
      key_down = !key_down;
      if (key_down) begin
        key_row = 2'($urandom_range(0, 3));
        key_col = 2'($urandom_range(0, 3));
        hold_left = $urandom_range(1, 2 * span + 6);
      end else begin
        hold_left = $urandom_range(1, int'(poll_period) + 4);
      end
    end
    hold_left--;
    case (key_col)
      2'd0:    lines = 4'hE;
      2'd1:    lines = 4'hD;
      2'd2:    lines = 4'hB;
      default: lines = 4'h7;
    endcase
    // A key only pulls its column low when its row is driven low.
    if (!key_down || (last_drive != '0 && last_drive[key_row])) lines = COLS_IDLE;
    if ($urandom_range(0, 99) < 12) lines = 4'($urandom_range(0, 15));
    return lines;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 50)
      $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Offers one sample, starting at a falling edge, and returns at the
  // falling edge after it was accepted with valid still high.
  task automatic send_sample(input logic [COLS_W-1:0] lines, input logic has_want,
                             input result_t want);
    result_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      smp.valid <= 1'b0;
      @(negedge clk);
    end
    smp.valid <= 1'b1;
    smp.column_sample <= lines;
    do @(posedge clk); while (!smp.ready);
    predicted = scan_tick(lines);
    last_drive = predicted.row_drive;
    expected_keys.push_back(has_want ? want : predicted);
    @(negedge clk);
  endtask

  // Writes one register. Valid is dropped before the task returns so that
  // back-to-back writes never assign it twice in one time step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_POLL_TICKS) poll_period = value;
    else if (idx == CFG_CONFIRM_TICKS) confirm_period = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every owed result has arrived, then lines up on a falling
  // edge. Every sample yields a result, so the block is idle after this.
  task automatic drain_results();
    while (expected_keys.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // One phase of random keypad activity under fixed periods and idling.
  task automatic run_keypad(input logic [CFG_DATA_W-1:0] poll_value,
                            input logic [CFG_DATA_W-1:0] confirm_value,
                            input int tx_pct, input int rx_pct, input int count,
                            input int holdoff);
    drain_results();
    write_reg(CFG_POLL_TICKS, poll_value);
    write_reg(CFG_CONFIRM_TICKS, confirm_value);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    rx_holdoff_req = holdoff;
    hold_left = 0;
    for (int i = 0; i < count; i++) send_sample(keypad_lines(), 1'b0, '0);
    smp.valid <= 1'b0;
  endtask

  // Result side: random stalls at the current rate, plus a long hold-off
  // when one is requested, so the input side backs up behind it.
  always @(negedge clk) begin
    if (rx_holdoff_req != 0) begin
      rx_holdoff_left = rx_holdoff_req;
      rx_holdoff_req = 0;
    end
    if (rx_holdoff_left > 0) begin
      rx_holdoff_left--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Every accepted result is checked against the oldest owed one.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && res.valid && res.ready) begin
      got = {res.row_drive, res.key_valid, res.key_code};
      if (expected_keys.size() == 0) begin
        report_mismatch("result with nothing pending", int'(got), 0);
      end else begin
        want = expected_keys.pop_front();
        if (got.row_drive !== want.row_drive)
          report_mismatch("row_drive", got.row_drive, want.row_drive);
        if (got.key_valid !== want.key_valid)
          report_mismatch("key_valid", got.key_valid, want.key_valid);
        if (got.key_code !== want.key_code)
          report_mismatch("key_code", got.key_code, want.key_code);
      end
    end
  end

  // Hang detector: any transaction on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (smp.valid && smp.ready) || (res.valid && res.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("** matrix_keypad_scanner_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    smp.valid = 1'b0;
    smp.column_sample = COLS_IDLE;
    res.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    mismatches = 0;
    quiet_cycles = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rx_holdoff_req = 0;
    rx_holdoff_left = 0;
    key_down = 1'b0;
    key_row = '0;
    key_col = '0;
    hold_left = 0;

    // Predictor reset mirrors the block's reset.
    pr_phase = PH_RELEASE;
    pr_ticks = '0;
    pr_row = '0;
    poll_period = POLL_TICKS_RESET;
    confirm_period = CONFIRM_TICKS_RESET;
    last_drive = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed script with one-tick periods, no idling on either side.
    write_reg(CFG_POLL_TICKS, 8'd1);
    write_reg(CFG_CONFIRM_TICKS, 8'd1);
    for (int i = 0; i < SCRIPT_LEN; i++)
      send_sample(KEY_SCRIPT[i].lines, KEY_SCRIPT[i].has_want, KEY_SCRIPT[i].want);
    smp.valid <= 1'b0;

    // Random keypad traffic. The phases step through the idling patterns
    // and the period settings, from zero up to the full eight bits.
    run_keypad(8'd1, 8'd1, 0, 0, 250, 0);
    run_keypad(8'd2, 8'd3, 88, 0, 200, 0);

    // Writes to indexes with no register behind them must change nothing;
    // the next phase then checks that a period of zero acts as one tick.
    drain_results();
    write_reg(CFG_NO_REG_LO, 8'hA5);
    write_reg(CFG_NO_REG_HI, 8'h5A);
    run_keypad(8'd0, 8'd0, 0, 88, 200, 0);

    run_keypad(8'd3, 8'd1, 33, 33, 200, 0);
    // Pressure: the result side holds off while samples keep coming.
    run_keypad(8'd1, 8'd2, 0, 0, 150, HOLDOFF_CYCLES);
    run_keypad(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)), 33, 33, 150, 0);
    run_keypad(POLL_TICKS_RESET, CONFIRM_TICKS_RESET, 0, 0, 150, 0);
    run_keypad(8'd255, 8'd255, 0, 0, 100, 0);

    drain_results();
    repeat (8) @(posedge clk);
    if (expected_keys.size() != 0)
      report_mismatch("results never delivered", expected_keys.size(), 0);

    if (mismatches == 0) begin
      $display("** matrix_keypad_scanner_unit: PASSED **");
    end else begin
      $display("** matrix_keypad_scanner_unit: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/mks_pkg.sv
rtl/mks_sample_if.sv
rtl/mks_result_if.sv
rtl/mks_cfg_if.sv
rtl/mks_core.sv
rtl/matrix_keypad_scanner_unit.sv
tb/tb_matrix_keypad_scanner_unit.sv
